### rtl/modexp_pkg.sv
// Package for the modular exponentiation block: widths, constants, control types.
package modexp_pkg;

  localparam int unsigned ExpBits = 63;
  localparam int unsigned ModBits = 31;
  localparam int unsigned BaseBits = 63;
  localparam int unsigned ProdBits = 2 * ModBits;
  localparam int unsigned DivBits = (BaseBits > ProdBits) ? BaseBits : ProdBits;
  localparam int unsigned DivCntBits = $clog2(DivBits + 1);
  localparam int unsigned ExpCntBits = $clog2(ExpBits + 1);
  localparam logic [ModBits-1:0] ModulusReset = ModBits'(1000000007);

  localparam logic OpPower = 1'b0;
  localparam logic OpInverse = 1'b1;

  typedef enum logic [3:0] {
    StIdle,
    StRedBase,
    StWaitBase,
    StSquare,
    StWaitSquare,
    StTestBit,
    StMult,
    StWaitMult,
    StNextBit,
    StOut
  } state_e;

  // Divider dividend source
  typedef enum logic [1:0] {
    SrcBase,
    SrcSquare,
    SrcMult
  } src_e;

  typedef struct packed {
    logic load;       // capture input item
    logic div_start;  // start a reduction
    src_e div_src;
    logic acc_write;  // take divider remainder into accumulator
    logic base_write; // take divider remainder into reduced base
    logic bit_next;   // step exponent bit counter
    logic out_load;   // move accumulator to output register
  } ctrl_t;

  typedef struct packed {
    logic div_done;
    logic exp_bit;
    logic last_bit;
    logic mod_small;
  } stat_t;

endpackage

### rtl/modexp_div.sv
// Restoring serial divider: one quotient bit per cycle, remainder only.
module modexp_div (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic [modexp_pkg::DivBits-1:0]   dividend_i,
  input  logic [modexp_pkg::ModBits-1:0]   divisor_i,
  output logic                             done_o,
  output logic [modexp_pkg::ModBits-1:0]   rem_o
);
  import modexp_pkg::*;

  logic [DivBits-1:0]    num_q, num_d;
  logic [ModBits:0]      rem_q, rem_d;
  logic [DivCntBits-1:0] cnt_q, cnt_d;
  logic                  busy_q, busy_d;
  logic                  done_q, done_d;
  logic [ModBits+1:0]    trial;

  // Shift in next dividend bit and try subtracting
  always_comb begin
    trial  = {rem_q, num_q[DivBits-1]};
    num_d  = num_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      num_d  = dividend_i;
      rem_d  = '0;
      cnt_d  = DivCntBits'(DivBits);
      busy_d = 1'b1;
    end else if (busy_q) begin
      num_d = {num_q[DivBits-2:0], 1'b0};
      if (trial >= {2'b0, divisor_i}) begin
        rem_d = (ModBits+1)'(trial - {2'b0, divisor_i});
      end else begin
        rem_d = trial[ModBits:0];
      end
      cnt_d = cnt_q - DivCntBits'(1);
      if (cnt_q == DivCntBits'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q[ModBits-1:0];

`ifndef SYNTHESIS
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q) else $error("divider done held");
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q) else $error("divider done while busy");
  a_rem_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && divisor_i != '0) |-> (rem_q < {1'b0, divisor_i}))
    else $error("remainder out of range");
`endif

endmodule

### rtl/modexp_dp.sv
// Datapath: operand registers, multiplier, shared divider, exponent scan.
module modexp_dp (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  modexp_pkg::ctrl_t                ctrl_i,
  output modexp_pkg::stat_t                stat_o,
  input  logic [modexp_pkg::ModBits-1:0]   modulus_i,
  input  logic                             opcode_i,
  input  logic [modexp_pkg::BaseBits-1:0]  base_value_i,
  input  logic [modexp_pkg::ExpBits-1:0]   exponent_i,
  output logic [modexp_pkg::ModBits-1:0]   result_o
);
  import modexp_pkg::*;

  logic [BaseBits-1:0]   base_raw_q;
  logic [ModBits-1:0]    base_q;
  logic [ModBits-1:0]    acc_q;
  logic [ExpBits-1:0]    exp_q;
  logic [ExpCntBits-1:0] bit_q;
  logic [ModBits-1:0]    res_q;
  logic [ProdBits-1:0]   prod_q;
  logic [DivBits-1:0]    dividend;
  logic                  div_done;
  logic [ModBits-1:0]    rem;
  logic [ModBits-1:0]    mul_b;

  // Operand capture, exponent bit counter, accumulator, reduced base and result register
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      base_raw_q <= base_value_i;
      if (opcode_i == OpInverse) begin
        exp_q <= ExpBits'(modulus_i - ModBits'(2));
      end else begin
        exp_q <= exponent_i;
      end
      bit_q <= ExpCntBits'(ExpBits - 1);
      acc_q <= ModBits'(1);
    end else begin
      if (ctrl_i.bit_next) bit_q <= bit_q - ExpCntBits'(1);
      if (ctrl_i.acc_write) acc_q <= rem;
    end
    if (ctrl_i.base_write) base_q <= rem;
    if (ctrl_i.out_load) res_q <= stat_o.mod_small ? '0 : acc_q;
  end

  // Product register feeding the divider
  assign mul_b = (ctrl_i.div_src == SrcMult) ? base_q : acc_q;
  always_ff @(posedge clk_i) begin
    prod_q <= ProdBits'(acc_q) * ProdBits'(mul_b);
  end

  always_comb begin
    unique case (ctrl_i.div_src)
      SrcBase: dividend = DivBits'(base_raw_q);
      default: dividend = DivBits'(prod_q);
    endcase
  end

  modexp_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (ctrl_i.div_start),
    .dividend_i (dividend),
    .divisor_i  (modulus_i),
    .done_o     (div_done),
    .rem_o      (rem)
  );

  assign stat_o.div_done  = div_done;
  assign stat_o.exp_bit   = exp_q[bit_q[ExpCntBits-1:0]];
  assign stat_o.last_bit  = (bit_q == '0);
  assign stat_o.mod_small = (modulus_i < ModBits'(2));
  assign result_o = res_q;

endmodule

### rtl/modexp_ctrl.sv
// Controller state machine sequencing base reduction and square-and-multiply.
module modexp_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  input  modexp_pkg::stat_t  stat_i,
  output modexp_pkg::ctrl_t  ctrl_o
);
  import modexp_pkg::*;

  state_e state_q, state_d;
  logic   ovalid_q, ovalid_d;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle:       if (in_valid_i) state_d = StRedBase;
      StRedBase:    state_d = stat_i.mod_small ? StOut : StWaitBase;
      StWaitBase:   if (stat_i.div_done) state_d = StSquare;
      StSquare:     state_d = StWaitSquare;
      StWaitSquare: if (stat_i.div_done) state_d = StTestBit;
      StTestBit:    state_d = stat_i.exp_bit ? StMult : StNextBit;
      StMult:       state_d = StWaitMult;
      StWaitMult:   if (stat_i.div_done) state_d = StNextBit;
      StNextBit:    state_d = stat_i.last_bit ? StOut : StSquare;
      StOut:        if (!ovalid_q || !out_stall_i) state_d = StIdle;
      default:      state_d = StIdle;
    endcase
  end

  // Outputs
  always_comb begin
    ctrl_o = '0;
    ctrl_o.div_src = SrcBase;
    unique case (state_q)
      StIdle:       ctrl_o.load = in_valid_i;
      StRedBase:    ctrl_o.div_start = !stat_i.mod_small;
      StWaitBase:   ctrl_o.base_write = stat_i.div_done;
      StSquare: begin
        ctrl_o.div_start = 1'b1;
        ctrl_o.div_src   = SrcSquare;
      end
      StWaitSquare: begin
        ctrl_o.div_src   = SrcSquare;
        ctrl_o.acc_write = stat_i.div_done;
      end
      // product register loads acc * base during StTestBit, ahead of the multiply in StMult
      StTestBit:    ctrl_o.div_src = SrcMult;
      StMult: begin
        ctrl_o.div_start = 1'b1;
        ctrl_o.div_src   = SrcMult;
      end
      StWaitMult: begin
        ctrl_o.div_src   = SrcMult;
        ctrl_o.acc_write = stat_i.div_done;
      end
      StNextBit:    ctrl_o.bit_next = !stat_i.last_bit;
      StOut:        ctrl_o.out_load = !ovalid_q || !out_stall_i;
      default:      ;
    endcase
  end

  // Output valid register
  always_comb begin
    ovalid_d = ovalid_q;
    if (ovalid_q && !out_stall_i) ovalid_d = 1'b0;
    if (ctrl_o.out_load) ovalid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      ovalid_q <= ovalid_d;
    end
  end

  assign in_stall_o  = (state_q != StIdle);
  assign out_valid_o = ovalid_q;

`ifndef SYNTHESIS
  a_load_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_o.load |-> state_q == StIdle) else $error("load outside idle");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ovalid_q && out_stall_i) |-> !ctrl_o.out_load) else $error("result overwritten");
  a_out_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_o.out_load |=> ovalid_q) else $error("result not shown");
`endif

endmodule

### rtl/modular_exponentiation_top.sv
// The base is reduced first, then per exponent bit the accumulator is squared and,
// for set bits, multiplied by the base, each step reduced in the serial divider.
// One item at a time, with exponents of up to 63 bits; every reduction uses the
// shared 63-step divider. The result register frees the core.
// Reset (rst_ni, async low) clears control and sets the modulus to 1000000007.
module modular_exponentiation_top (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [modexp_pkg::ModBits-1:0]   cfg_wdata_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic                             opcode_i,
  input  logic [modexp_pkg::BaseBits-1:0]  base_value_i,
  input  logic [modexp_pkg::ExpBits-1:0]   exponent_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [modexp_pkg::ModBits-1:0]   result_o
);
  import modexp_pkg::*;

  logic [ModBits-1:0] modulus_q;
  ctrl_t              ctrl;
  stat_t              stat;

  // Modulus register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modulus_q <= ModulusReset;
    end else if (cfg_we_i) begin
      modulus_q <= cfg_wdata_i;
    end
  end

  modexp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .ctrl_o      (ctrl)
  );

  modexp_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (ctrl),
    .stat_o       (stat),
    .modulus_i    (modulus_q),
    .opcode_i     (opcode_i),
    .base_value_i (base_value_i),
    .exponent_i   (exponent_i),
    .result_o     (result_o)
  );

endmodule

### tb/testbench.sv
// Testbench for the modular exponentiation block: directed and random items checked by a scoreboard.
`timescale 1ns / 100ps

module testbench;
  import modexp_pkg::*;

  // Expected-result store and comparison
  class modexp_scoreboard;
    logic [ModBits-1:0] pending_q[$];
    int unsigned mismatches;
    int unsigned results_seen;
    int unsigned items_seen;
    logic [ModBits-1:0] modulus;

    function new();
      modulus = ModulusReset;
    endfunction

    // square-and-multiply from the top exponent bit down
    function logic [ModBits-1:0] predict_power(logic opcode, logic [BaseBits-1:0] base,
                                               logic [ExpBits-1:0] expo);
      logic [63:0] m;
      logic [63:0] b;
      logic [63:0] acc;
      logic [ExpBits-1:0] e;
      m = 64'(modulus);
      if (m < 2) return '0;
      e = (opcode == OpInverse) ? ExpBits'(m - 2) : expo;
      b = 64'(base) % m;
      acc = 64'd1;
      for (int i = ExpBits - 1; i >= 0; i--) begin
        acc = (acc * acc) % m;
        if (e[i]) acc = (acc * b) % m;
      end
      return ModBits'(acc);
    endfunction

    function void note_item(logic opcode, logic [BaseBits-1:0] base, logic [ExpBits-1:0] expo);
      pending_q = {pending_q, predict_power(opcode, base, expo)};
      items_seen++;
    endfunction

    function void check_result(logic [ModBits-1:0] got);
      logic [ModBits-1:0] want;
      results_seen++;
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %0d", got);
        return;
      end
      want = pending_q.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10) $display("result: expected %0d got %0d", want, got);
      end
    endfunction
  endclass

  logic clk_i, rst_ni;
  logic cfg_we_i;
  logic [ModBits-1:0] cfg_wdata_i;
  logic in_valid_i, in_stall_o;
  logic opcode_i;
  logic [BaseBits-1:0] base_value_i;
  logic [ExpBits-1:0] exponent_i;
  logic out_valid_o, out_stall_i;
  logic [ModBits-1:0] result_o;

  modexp_scoreboard board;
  int unsigned cycle_count;
  bit hold_off;
  bit stall_on;
  bit quiet_out;

  localparam int unsigned CycleLimit = 4000000;

  modular_exponentiation_top uut (.*);

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("modular_exponentiation_top: mismatch");
      $finish;
    end
  end

  // Receiver: random stall, long hold-off on request
  always @(posedge clk_i) begin
    if (out_valid_o && !out_stall_i) board.check_result(result_o);
    if (hold_off) out_stall_i <= 1'b1;
    else if (quiet_out || !stall_on) out_stall_i <= 1'b0;
    else out_stall_i <= ($urandom_range(0, 9) < 2) ||
                        ($urandom_range(0, 99) == 0 && $urandom_range(0, 1) == 0);
  end

  function automatic logic [62:0] rand63();
    return 63'({$urandom(), $urandom()});
  endfunction

  function automatic logic [62:0] rand_field();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return 63'($urandom_range(0, 40));
      3: return 63'($urandom());
      default: return rand63();
    endcase
  endfunction

  // Drop valid and wait for a clock edge
  task automatic release_inputs();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic random_gap(input bit enable);
    int unsigned n;
    if (!enable) return;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 200) : $urandom_range(0, 3);
    if (n == 0) return;
    in_valid_i <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  // Offer one item and wait until it is accepted
  task automatic send_item(input logic op, input logic [62:0] base, input logic [62:0] expo,
                           input bit gaps);
    random_gap(gaps);
    in_valid_i <= 1'b1;
    opcode_i <= op;
    base_value_i <= base;
    exponent_i <= expo;
    do @(posedge clk_i); while (in_stall_o);
    board.note_item(op, base, expo);
  endtask

  task automatic drain();
    release_inputs();
    while (board.pending_q.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  task automatic write_modulus(input logic [ModBits-1:0] value);
    drain();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    board.modulus = value;
  endtask

  // Random run of count items with random opcodes, fields and input gaps
  task automatic run_phase(input int unsigned count);
    for (int i = 0; i < count; i++)
      send_item($urandom_range(0, 3) == 0, rand_field(), rand_field(), $urandom_range(0, 3) != 0);
  endtask

  initial begin
    board = new();
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    in_valid_i = 1'b0;
    opcode_i = OpPower;
    base_value_i = '0;
    exponent_i = '0;
    out_stall_i = 1'b0;
    hold_off = 1'b0;
    stall_on = 1'b0;
    quiet_out = 1'b0;
    cycle_count = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // extremes, zero exponent, both opcodes, zero base
    send_item(OpPower, 63'd5, 63'd0, 0);
    send_item(OpPower, '1, '1, 0);
    send_item(OpPower, '0, 63'd7, 0);
    send_item(OpPower, '0, '0, 0);
    send_item(OpInverse, 63'd2, '1, 0);
    send_item(OpInverse, '0, 63'd3, 0);
    send_item(OpInverse, '1, '0, 0);
    send_item(OpPower, 63'd1000000007, 63'd5, 0);
    send_item(OpPower, 63'h2aaa_aaaa_aaaa_aaaa, 63'h5555_5555_5555_5555, 0);

    // block fills up while the receiver holds off
    hold_off = 1'b1;
    fork
      begin
        repeat (6) send_item(OpPower, rand63(), 63'($urandom_range(0, 255)), 0);
        release_inputs();
      end
      begin
        repeat (15000) @(posedge clk_i);
        hold_off = 1'b0;
      end
    join

    stall_on = 1'b1;
    run_phase(30);

    // modulus two and the top of the range, then primes and a composite
    write_modulus(ModBits'(2));
    send_item(OpInverse, 63'd3, 63'd9, 0);
    send_item(OpPower, 63'd3, 63'd9, 0);
    send_item(OpPower, 63'd4, 63'd0, 0);
    write_modulus('1);
    run_phase(15);
    write_modulus(ModBits'(13));
    run_phase(12);
    write_modulus(ModBits'(1000));
    run_phase(12);
    write_modulus(ModBits'($urandom_range(2, 32'h7fff_ffff)));
    run_phase(12);
    write_modulus(ModBits'(3));
    run_phase(8);
    quiet_out = 1'b1;
    write_modulus(ModulusReset);
    run_phase(8);
    drain();

    $display("covered %0d items, %0d results, across seven modulus settings",
             board.items_seen, board.results_seen);
    $display("both opcodes, zero and full-width fields, receiver hold-off included");
    if (board.mismatches == 0 && board.pending_q.size() == 0) begin
      $display("modular_exponentiation_top: match");
    end else begin
      $display("%0d mismatches, %0d left pending", board.mismatches, board.pending_q.size());
      $display("modular_exponentiation_top: mismatch");
    end
    $finish;
  end

endmodule
